/* src/assert_macros.svh */
// Assertion macros shared by the matrix inverse RTL.
// Each macro is one clocked implication with a reset disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MI3_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MI3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/mi3_pkg.sv */
// Package for the 3x3 matrix inverse: lane operand tables and pipeline constants.
// Used by every module of the block; depends on nothing.
package mi3_pkg;

  typedef logic pipe_en_t;

  localparam int unsigned NUM_ELEMS = 9;
  localparam int unsigned COF_LAT   = 2;
  localparam int unsigned DET_LAT   = 3;

  typedef int unsigned cof_ops_t [NUM_ELEMS][4];

  // Cofactor k is elem[i0]*elem[i1] - elem[i2]*elem[i3], elements by row.
  localparam cof_ops_t COF_OPS = '{
    '{4, 8, 5, 7},
    '{2, 7, 1, 8},
    '{1, 5, 2, 4},
    '{5, 6, 3, 8},
    '{0, 8, 2, 6},
    '{2, 3, 0, 5},
    '{3, 7, 4, 6},
    '{1, 6, 0, 7},
    '{0, 4, 1, 3}
  };

endpackage

/* src/mi3_cof_lane.sv */
// One cofactor lane: two registered products and their registered difference.
// Depends on mi3_pkg.
module mi3_cof_lane import mi3_pkg::*; #(
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  logic                          clk,
  input  pipe_en_t                      en,
  input  logic signed [ELEM_WIDTH-1:0]  x0,
  input  logic signed [ELEM_WIDTH-1:0]  y0,
  input  logic signed [ELEM_WIDTH-1:0]  x1,
  input  logic signed [ELEM_WIDTH-1:0]  y1,
  output logic signed [2*ELEM_WIDTH:0]  cof
);
  localparam int unsigned PW = 2 * ELEM_WIDTH;

  logic signed [PW-1:0] p0_r, p1_r;
  logic signed [PW:0]   cof_r, cof_nxt;

  assign cof_nxt = {p0_r[PW-1], p0_r} - {p1_r[PW-1], p1_r};

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r  <= x0 * y0;
      p1_r  <= x1 * y1;
      cof_r <= cof_nxt;
    end
  end

  assign cof = cof_r;
endmodule

/* src/mi3_det.sv */
// Merging stage: combines the first-row cofactors into the determinant.
// Splits each wide multiply into two partial products. Depends on mi3_pkg.
module mi3_det import mi3_pkg::*; #(
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  logic                            clk,
  input  pipe_en_t                        en,
  input  logic signed [ELEM_WIDTH-1:0]    a [3],
  input  logic signed [2*ELEM_WIDTH:0]    c [3],
  output logic signed [3*ELEM_WIDTH+2:0]  det
);
  localparam int unsigned W  = ELEM_WIDTH;
  localparam int unsigned PW = 2 * W + 1;
  localparam int unsigned DW = 3 * W + 3;

  logic signed [PW-1:0] ph_r [3];
  logic signed [PW-1:0] pl_r [3];
  logic signed [DW-1:0] term_r [3];
  logic signed [DW-1:0] det_r;

  for (genvar k = 0; k < 3; k++) begin : g_term
    logic signed [W:0]    c_hi;
    logic signed [W:0]    c_lo;
    logic signed [DW-1:0] term_nxt;
    assign c_hi = c[k][2*W:W];
    assign c_lo = $signed({1'b0, c[k][W-1:0]});
    assign term_nxt = ($signed(DW'(ph_r[k])) <<< W) + $signed(DW'(pl_r[k]));
    always_ff @(posedge clk) begin
      if (en) begin
        ph_r[k]   <= a[k] * c_hi;
        pl_r[k]   <= a[k] * c_lo;
        term_r[k] <= term_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= term_r[0] + term_r[1] + term_r[2];
    end
  end

  assign det = det_r;
endmodule

/* src/mi3_div_lane.sv */
// One divider lane: restoring division pipeline, one quotient bit per stage,
// with overflow detection and saturation to the element width. Depends on mi3_pkg.
module mi3_div_lane import mi3_pkg::*; #(
  parameter int unsigned ELEM_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                                     clk,
  input  pipe_en_t                                 en,
  input  logic [2*ELEM_WIDTH+2*FRAC_BITS:0]        num_mag,
  input  logic [3*ELEM_WIDTH+2:0]                  den_mag,
  input  logic                                     neg,
  output logic signed [ELEM_WIDTH-1:0]             quo
);
  localparam int unsigned W  = ELEM_WIDTH;
  localparam int unsigned NW = 2 * W + 1 + 2 * FRAC_BITS;
  localparam int unsigned DW = 3 * W + 3;
  localparam logic [W-1:0] QMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] QMIN = {1'b1, {(W-1){1'b0}}};

  logic [DW-1:0] rem_r [W];
  logic [W-1:0]  lo_r  [W];
  logic [W-1:0]  q_r   [W];
  logic [DW-1:0] den_r [W];
  logic          neg_r [W];
  logic          ovf_r [W];
  logic [W-1:0]  quo_r, quo_nxt;

  logic [NW-W-1:0] num_hi;
  logic            ovf0;
  logic [DW-1:0]   rem0;

  assign num_hi = num_mag[NW-1:W];
  assign ovf0   = DW'(num_hi) >= den_mag;
  assign rem0   = ovf0 ? '0 : DW'(num_hi);

  for (genvar s = 0; s < W; s++) begin : g_stage
    logic [DW-1:0] rin, din, rem_nxt;
    logic [W-1:0]  lin, qin;
    logic          nin, oin, ge;
    logic [DW:0]   t;
    if (s == 0) begin : g_first
      assign rin = rem0;
      assign lin = num_mag[W-1:0];
      assign qin = '0;
      assign din = den_mag;
      assign nin = neg;
      assign oin = ovf0;
    end else begin : g_rest
      assign rin = rem_r[s-1];
      assign lin = lo_r[s-1];
      assign qin = q_r[s-1];
      assign din = den_r[s-1];
      assign nin = neg_r[s-1];
      assign oin = ovf_r[s-1];
    end
    assign t       = {rin, lin[W-1]};
    assign ge      = t >= {1'b0, din};
    assign rem_nxt = ge ? DW'(t - {1'b0, din}) : t[DW-1:0];
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        lo_r[s]  <= lin << 1;
        q_r[s]   <= {qin[W-2:0], ge};
        den_r[s] <= din;
        neg_r[s] <= nin;
        ovf_r[s] <= oin;
      end
    end
  end

  always_comb begin
    if (neg_r[W-1]) begin
      quo_nxt = (ovf_r[W-1] || q_r[W-1] > QMIN) ? QMIN : W'(-q_r[W-1]);
    end else begin
      quo_nxt = (ovf_r[W-1] || q_r[W-1] > QMAX) ? QMAX : q_r[W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= quo_nxt;
    end
  end

  assign quo = $signed(quo_r);
endmodule

/* src/matrix3x3_inverse.sv */
// 3x3 matrix inverse in signed fixed point (Q16.16 by default).
// Input channel: in_valid/in_ready with the nine elements in_a00..in_a22 by row.
// Result channel: out_valid/out_ready with out_r00..out_r22, out_determinant
// and out_singular. One result is returned for every input transfer, in order.
// The block is a fixed pipeline: nine cofactor lanes, a determinant stage that
// merges the first-row cofactors, a preparation stage, then nine divider lanes
// of ELEM_WIDTH restoring stages each. Throughput is one matrix per cycle
// while the receiver does not stall.
// A zero determinant raises out_singular and returns zeros for all elements
// and the determinant. Results outside the element range saturate.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready falls; it rises again in the cycle the result is taken.
// Reset (rst_n low, synchronous) empties the pipeline; no result is lost or
// invented by a stall, and reset needs no further initialization.
module matrix3x3_inverse import mi3_pkg::*; #(
  parameter int unsigned ELEM_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [ELEM_WIDTH-1:0]  in_a00,
  input  logic signed [ELEM_WIDTH-1:0]  in_a01,
  input  logic signed [ELEM_WIDTH-1:0]  in_a02,
  input  logic signed [ELEM_WIDTH-1:0]  in_a10,
  input  logic signed [ELEM_WIDTH-1:0]  in_a11,
  input  logic signed [ELEM_WIDTH-1:0]  in_a12,
  input  logic signed [ELEM_WIDTH-1:0]  in_a20,
  input  logic signed [ELEM_WIDTH-1:0]  in_a21,
  input  logic signed [ELEM_WIDTH-1:0]  in_a22,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [ELEM_WIDTH-1:0]  out_r00,
  output logic signed [ELEM_WIDTH-1:0]  out_r01,
  output logic signed [ELEM_WIDTH-1:0]  out_r02,
  output logic signed [ELEM_WIDTH-1:0]  out_r10,
  output logic signed [ELEM_WIDTH-1:0]  out_r11,
  output logic signed [ELEM_WIDTH-1:0]  out_r12,
  output logic signed [ELEM_WIDTH-1:0]  out_r20,
  output logic signed [ELEM_WIDTH-1:0]  out_r21,
  output logic signed [ELEM_WIDTH-1:0]  out_r22,
  output logic signed [ELEM_WIDTH-1:0]  out_determinant,
  output logic                          out_singular
);
  `include "assert_macros.svh"

  localparam int unsigned W   = ELEM_WIDTH;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned CW  = 2 * W + 1;
  localparam int unsigned DW  = 3 * W + 3;
  localparam int unsigned NW  = CW + 2 * F;
  localparam int unsigned LAT = COF_LAT + DET_LAT + 1 + W + 1;
  localparam logic signed [W-1:0] EMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] EMIN = {1'b1, {(W-1){1'b0}}};

  pipe_en_t en;
  logic     vld_r [LAT];

  logic signed [W-1:0]  elem [NUM_ELEMS];
  logic signed [CW-1:0] cof  [NUM_ELEMS];
  logic signed [W-1:0]  a_d1_r [3];
  logic signed [W-1:0]  a_d2_r [3];
  logic signed [CW-1:0] cd_r [DET_LAT][NUM_ELEMS];
  logic signed [CW-1:0] det_c [3];
  logic signed [DW-1:0] det;

  logic [NW-1:0]  num_mag_r [NUM_ELEMS];
  logic           neg_r     [NUM_ELEMS];
  logic [DW-1:0]  den_mag_r;
  logic [W-1:0]   dd_r [W+2];
  logic           sg_r [W+2];
  logic signed [W-1:0] quo [NUM_ELEMS];

  logic [DW-1:0]        det_mag;
  logic signed [DW-1:0] det_q;
  logic [W-1:0]         det_sat;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  assign elem[0] = in_a00;
  assign elem[1] = in_a01;
  assign elem[2] = in_a02;
  assign elem[3] = in_a10;
  assign elem[4] = in_a11;
  assign elem[5] = in_a12;
  assign elem[6] = in_a20;
  assign elem[7] = in_a21;
  assign elem[8] = in_a22;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  for (genvar k = 0; k < NUM_ELEMS; k++) begin : g_cof
    mi3_cof_lane #(.ELEM_WIDTH(W)) u_cof (
      .clk (clk),
      .en  (en),
      .x0  (elem[COF_OPS[k][0]]),
      .y0  (elem[COF_OPS[k][1]]),
      .x1  (elem[COF_OPS[k][2]]),
      .y1  (elem[COF_OPS[k][3]]),
      .cof (cof[k])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_d1_r[0] <= in_a00;
      a_d1_r[1] <= in_a01;
      a_d1_r[2] <= in_a02;
      a_d2_r    <= a_d1_r;
      cd_r[0]   <= cof;
      for (int i = 1; i < DET_LAT; i++) cd_r[i] <= cd_r[i-1];
    end
  end

  assign det_c[0] = cof[0];
  assign det_c[1] = cof[3];
  assign det_c[2] = cof[6];

  mi3_det #(.ELEM_WIDTH(W)) u_det (
    .clk (clk),
    .en  (en),
    .a   (a_d2_r),
    .c   (det_c),
    .det (det)
  );

  assign det_mag = det[DW-1] ? DW'(-det) : DW'(det);

  always_comb begin
    det_q = det[DW-1] ? -$signed(det_mag >> (2 * F)) : $signed(det_mag >> (2 * F));
    if (det_q > EMAX) begin
      det_sat = EMAX;
    end else if (det_q < EMIN) begin
      det_sat = EMIN;
    end else begin
      det_sat = det_q[W-1:0];
    end
  end

  for (genvar k = 0; k < NUM_ELEMS; k++) begin : g_div
    logic signed [NW-1:0] num;
    assign num = $signed(NW'(cd_r[DET_LAT-1][k])) <<< (2 * F);
    always_ff @(posedge clk) begin
      if (en) begin
        num_mag_r[k] <= num[NW-1] ? NW'(-num) : NW'(num);
        neg_r[k]     <= num[NW-1] ^ det[DW-1];
      end
    end
    mi3_div_lane #(.ELEM_WIDTH(W), .FRAC_BITS(F)) u_div (
      .clk     (clk),
      .en      (en),
      .num_mag (num_mag_r[k]),
      .den_mag (den_mag_r),
      .neg     (neg_r[k]),
      .quo     (quo[k])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_mag_r <= det_mag;
      dd_r[0]   <= det_sat;
      sg_r[0]   <= (det == '0);
      for (int i = 1; i <= W + 1; i++) begin
        dd_r[i] <= dd_r[i-1];
        sg_r[i] <= sg_r[i-1];
      end
    end
  end

  assign out_valid       = vld_r[LAT-1];
  assign out_singular    = sg_r[W+1];
  assign out_determinant = sg_r[W+1] ? '0 : $signed(dd_r[W+1]);
  assign out_r00 = sg_r[W+1] ? '0 : quo[0];
  assign out_r01 = sg_r[W+1] ? '0 : quo[1];
  assign out_r02 = sg_r[W+1] ? '0 : quo[2];
  assign out_r10 = sg_r[W+1] ? '0 : quo[3];
  assign out_r11 = sg_r[W+1] ? '0 : quo[4];
  assign out_r12 = sg_r[W+1] ? '0 : quo[5];
  assign out_r20 = sg_r[W+1] ? '0 : quo[6];
  assign out_r21 = sg_r[W+1] ? '0 : quo[7];
  assign out_r22 = sg_r[W+1] ? '0 : quo[8];

  `MI3_ASSERT_SAME(a_ready_only_on_stall, clk, rst_n, !in_ready, out_valid && !out_ready,
    "input ready dropped without an output stall")
  `MI3_ASSERT_NEXT(a_accept_enters, clk, rst_n, in_valid && in_ready, vld_r[0],
    "accepted item did not enter the pipeline")
  `MI3_ASSERT_SAME(a_singular_zero, clk, rst_n, out_valid && out_singular,
    out_determinant == '0 && out_r00 == '0 && out_r11 == '0 && out_r22 == '0,
    "singular result with nonzero fields")
endmodule
